// ===== rtl/core/ppsp_pkg.sv =====
// ppsp_pkg: transaction types and result codes of the ppm p6 stream parser
// no dependencies; imported by the parser top level and its checker
package ppsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  error_code;
        logic [7:0]  pixel_byte;
        logic [1:0]  color_channel;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

    localparam logic [1:0] ST_HEADER   = 2'd0;
    localparam logic [1:0] ST_PIXEL    = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_NUMBER    = 4'd2;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd3;
    localparam logic [3:0] ERR_MAXVAL    = 4'd4;
    localparam logic [3:0] ERR_SEPARATOR = 4'd5;
    localparam logic [3:0] ERR_TRUNCATED = 4'd6;
    localparam logic [3:0] ERR_SHORT     = 4'd7;
    localparam logic [3:0] ERR_LONG      = 4'd8;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] MAXVAL_REQ = 8'd255;

endpackage

// ===== rtl/core/ppm_p6_stream_parser.sv =====
// ppm_p6_stream_parser: the result of a byte is registered at the edge that accepts it,
// in the result register or skid entry; throughput one byte per cycle while the skid
// entry is empty, set by the per-byte header/payload update before the result register
// a skid entry beside the result register takes one more byte while a result is stalled
// rst_n clears the parser to expect 'P'; each end-of-file byte returns it there too
// depends on ppsp_pkg
module ppm_p6_stream_parser
    import ppsp_pkg::*;
#(
    parameter int MAX_DIMENSION = 65535
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int NUM_W = $clog2(MAX_DIMENSION + 1);
    localparam int ACC_W = NUM_W + 4;
    localparam logic [ACC_W-1:0] MAX_VAL = ACC_W'(MAX_DIMENSION);

    localparam logic [3:0] PH_MAGIC_P = 4'd0;
    localparam logic [3:0] PH_MAGIC_6 = 4'd1;
    localparam logic [3:0] PH_PRE_W   = 4'd2;
    localparam logic [3:0] PH_NUM_W   = 4'd3;
    localparam logic [3:0] PH_PRE_H   = 4'd4;
    localparam logic [3:0] PH_NUM_H   = 4'd5;
    localparam logic [3:0] PH_PRE_M   = 4'd6;
    localparam logic [3:0] PH_NUM_M   = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_TRAIL   = 4'd9;
    localparam logic [3:0] PH_ERROR   = 4'd10;

    logic [3:0]       phase_reg, phase_next;
    logic             comment_reg, comment_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [NUM_W-1:0] width_reg, width_next;
    logic [NUM_W-1:0] height_reg, height_next;
    logic [NUM_W-1:0] col_reg, col_next;
    logic [NUM_W-1:0] row_reg, row_next;
    logic [1:0]       chan_reg, chan_next;
    logic [3:0]       held_reg, held_next;

    result_t out_reg, skid_reg, new_result;
    logic    out_valid_reg, skid_valid_reg;

    logic [7:0]       b;
    logic             eof;
    logic             accept;
    logic             is_ws, is_digit;
    logic [ACC_W-1:0] digit_sum;
    logic             digit_over;
    logic [NUM_W:0]   col_inc, row_inc;
    logic             fail;
    logic [3:0]       fail_code;
    logic [1:0]       r_status;
    logic [3:0]       r_code;
    logic [7:0]       r_pixel;
    logic [1:0]       r_chan;

    assign b      = item.data_byte;
    assign eof    = item.end_of_file;
    assign accept = item_valid && !item_stall;

    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign is_ws    = (b inside {[8'd9:8'd13], 8'd32});
    assign is_digit = (b inside {[8'd48:8'd57]});

    // acc*10 + digit, low nibble of an ascii digit is its value
    assign digit_sum  = ACC_W'({acc_reg, 3'b000}) + ACC_W'({acc_reg, 1'b0}) + ACC_W'(b[3:0]);
    assign digit_over = digit_sum > MAX_VAL;

    assign col_inc = (NUM_W+1)'(col_reg) + (NUM_W+1)'(1);
    assign row_inc = (NUM_W+1)'(row_reg) + (NUM_W+1)'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        acc_next     = acc_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        chan_next    = chan_reg;
        held_next    = held_reg;
        fail         = 1'b0;
        fail_code    = ERR_NONE;
        r_status     = ST_HEADER;
        r_code       = ERR_NONE;
        r_pixel      = 8'd0;
        r_chan       = 2'd0;

        if (phase_reg == PH_ERROR)
        begin
            r_status = ST_ERROR;
            r_code   = held_reg;
        end
        else if (phase_reg == PH_TRAIL)
        begin
            fail      = 1'b1;
            fail_code = ERR_LONG;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            r_pixel  = b;
            r_chan   = chan_reg;
            r_status = ST_PIXEL;
            chan_next = chan_reg + 2'd1;
            if (chan_reg == 2'd2)
            begin
                chan_next = 2'd0;
                col_next  = col_inc[NUM_W-1:0];
                if (col_inc >= {1'b0, width_reg})
                begin
                    col_next = '0;
                    row_next = row_inc[NUM_W-1:0];
                    if (row_inc >= {1'b0, height_reg})
                    begin
                        phase_next = PH_TRAIL;
                        r_status   = eof ? ST_COMPLETE : ST_PIXEL;
                    end
                end
            end
        end
        else if (comment_reg)
        begin
            if (b == CHAR_LF || b == CHAR_CR)
            begin
                comment_next = 1'b0;
            end
        end
        else if (b == CHAR_HASH)
        begin
            comment_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC_P:
                begin
                    if (b == CHAR_P)
                        phase_next = PH_MAGIC_6;
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_MAGIC;
                    end
                end
                PH_MAGIC_6:
                begin
                    if (b == CHAR_6)
                        phase_next = PH_PRE_W;
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_MAGIC;
                    end
                end
                PH_PRE_W, PH_PRE_H, PH_PRE_M:
                begin
                    if (is_digit)
                    begin
                        // first digit never exceeds the bound
                        acc_next   = NUM_W'(b[3:0]);
                        phase_next = phase_reg + 4'd1;
                    end
                    else if (!is_ws)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_NUMBER;
                    end
                end
                PH_NUM_W, PH_NUM_H:
                begin
                    if (is_digit)
                    begin
                        if (digit_over)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TOO_LARGE;
                        end
                        else
                            acc_next = digit_sum[NUM_W-1:0];
                    end
                    else if (acc_reg == '0 || !is_ws)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_NUMBER;
                    end
                    else if (phase_reg == PH_NUM_W)
                    begin
                        width_next = acc_reg;
                        phase_next = PH_PRE_H;
                    end
                    else
                    begin
                        height_next = acc_reg;
                        phase_next  = PH_PRE_M;
                    end
                end
                PH_NUM_M:
                begin
                    if (is_digit)
                    begin
                        if (digit_over)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TOO_LARGE;
                        end
                        else
                            acc_next = digit_sum[NUM_W-1:0];
                    end
                    else if (acc_reg == '0)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_NUMBER;
                    end
                    else if (acc_reg != NUM_W'(MAXVAL_REQ))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_MAXVAL;
                    end
                    else if (!is_ws)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_SEPARATOR;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        col_next   = '0;
                        row_next   = '0;
                        chan_next  = 2'd0;
                    end
                end
                default:
                begin
                    fail      = 1'b1;
                    fail_code = ERR_NUMBER;
                end
            endcase
        end

        if (fail)
        begin
            phase_next = PH_ERROR;
            held_next  = fail_code;
            r_status   = ST_ERROR;
            r_code     = fail_code;
            r_pixel    = 8'd0;
            r_chan     = 2'd0;
        end

        // end of file that leaves the image unfinished
        if (eof && r_status != ST_COMPLETE && r_status != ST_ERROR)
        begin
            r_status = ST_ERROR;
            r_code   = (phase_next == PH_PAYLOAD) ? ERR_SHORT : ERR_TRUNCATED;
            r_pixel  = 8'd0;
            r_chan   = 2'd0;
        end

        new_result.status        = r_status;
        new_result.error_code    = r_code;
        new_result.pixel_byte    = r_pixel;
        new_result.color_channel = r_chan;
        new_result.image_width   = 16'(width_next);
        new_result.image_height  = 16'(height_next);

        // every file ends with a return to the reset state
        if (eof)
        begin
            phase_next   = PH_MAGIC_P;
            comment_next = 1'b0;
            acc_next     = '0;
            width_next   = '0;
            height_next  = '0;
            col_next     = '0;
            row_next     = '0;
            chan_next    = 2'd0;
            held_next    = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC_P;
            comment_reg <= 1'b0;
            acc_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            chan_reg    <= 2'd0;
            held_reg    <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            acc_reg     <= acc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            chan_reg    <= chan_next;
            held_reg    <= held_next;
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : new_result;
        end
        else if (accept)
        begin
            skid_reg <= new_result;
        end
    end

endmodule

// ===== rtl/core/ppsp_checker.sv =====
// ppsp_checker: port-level assertions for the ppm p6 stream parser
// depends on ppsp_pkg; bound to ppm_p6_stream_parser at the end of this file
module ppsp_checker
    import ppsp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input side only backs up once a result is waiting
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty output");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_ERROR |-> result.error_code != ERR_NONE)
        else $error("error status without code");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_ERROR |-> result.error_code == ERR_NONE)
        else $error("error code outside error status");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_PIXEL || result.status == ST_COMPLETE)
        |-> result.color_channel != 2'd3)
        else $error("color channel out of range");

endmodule

bind ppm_p6_stream_parser ppsp_checker u_ppsp_checker (.*);
